### design/rte_pkg.sv
// Shared types and the CORDIC angle table for the rotation-to-Euler block.
package rte_pkg;

  // Width of one binary-angle accumulator (2^31 = pi, with headroom).
  localparam int ZW = 34;
  // Number of entries in the arctangent table.
  localparam int ATAN_LEN = 24;
  // Integer square root: result bits and remainder width.
  localparam int ROOT_W = 16;
  localparam int REM_W  = 19;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
  } mat_t;

  typedef struct packed {
    mat_t              mat;
    logic [31:0]       sum;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // atan(2^-i) in units where 2^31 = pi
  function automatic logic [31:0] atan_at(input int idx);
    logic [31:0] v;
    begin
      case (idx)
        0:  v = 32'h20000000;
        1:  v = 32'h12E4051E;
        2:  v = 32'h09FB385B;
        3:  v = 32'h051111D4;
        4:  v = 32'h028B0D43;
        5:  v = 32'h0145D7E1;
        6:  v = 32'h00A2F61E;
        7:  v = 32'h00517C55;
        8:  v = 32'h0028BE53;
        9:  v = 32'h00145F2F;
        10: v = 32'h000A2F98;
        11: v = 32'h000517CC;
        12: v = 32'h00028BE6;
        13: v = 32'h000145F3;
        14: v = 32'h0000A2F9;
        15: v = 32'h0000517C;
        16: v = 32'h000028BE;
        17: v = 32'h0000145F;
        18: v = 32'h00000A2F;
        19: v = 32'h00000517;
        20: v = 32'h0000028B;
        21: v = 32'h00000145;
        22: v = 32'h000000A2;
        23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      return v;
    end
  endfunction

endpackage

### design/rte_ifs.sv
// Channel interfaces: matrix input, angle result and limit register write.
interface rte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r00;
  logic signed [15:0] r10;
  logic signed [15:0] r20;
  logic signed [15:0] r21;
  logic signed [15:0] r22;
  logic signed [15:0] r11;
  logic signed [15:0] r12;
  modport source (output valid, r00, r10, r20, r21, r22, r11, r12, input ready);
  modport sink   (input valid, r00, r10, r20, r21, r22, r11, r12, output ready);
endinterface

interface rte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic               singular;
  modport source (output valid, angle_x, angle_y, angle_z, singular, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, singular, output ready);
endinterface

interface rte_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] singular_limit;
  modport source (output valid, singular_limit, input ready);
  modport sink   (input valid, singular_limit, output ready);
endinterface

### design/rte_sqrt_cell.sv
// One digit cell of the pipelined integer square root (two radicand bits per cell).
module rte_sqrt_cell #(
  parameter int PAIR = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  rte_pkg::sqrt_t in_data,
  output logic           out_valid,
  output rte_pkg::sqrt_t out_data
);
  import rte_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  sqrt_t            data_nxt;
  logic             valid_r;
  sqrt_t            data_r;

  // bring down the next bit pair and try the root digit
  always_comb begin
    rem_sh   = {in_data.rem[REM_W-3:0], in_data.sum[2*PAIR+1 -: 2]};
    trial    = {{(REM_W-ROOT_W-2){1'b0}}, in_data.root, 2'b01};
    data_nxt = in_data;
    if (rem_sh >= trial) begin
      data_nxt.rem  = rem_sh - trial;
      data_nxt.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_nxt.rem  = rem_sh;
      data_nxt.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  // advance the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

### design/rte_cordic_entry.sv
// CORDIC entry cell: scale operands, fold the left half-plane, flag the origin.
module rte_cordic_entry #(
  parameter int W     = 39,
  parameter int SHIFT = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [16:0]         op_y,
  input  logic signed [16:0]         op_x,
  output logic signed [W-1:0]        x_out,
  output logic signed [W-1:0]        y_out,
  output logic signed [rte_pkg::ZW-1:0] z_out,
  output logic                       zero_out
);
  import rte_pkg::*;

  logic signed [W-1:0]  xs;
  logic signed [W-1:0]  ys;
  logic signed [W-1:0]  x_nxt;
  logic signed [W-1:0]  y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [W-1:0]  x_r;
  logic signed [W-1:0]  y_r;
  logic signed [ZW-1:0] z_r;
  logic                 zero_r;

  // scale and rotate by pi when x is negative
  always_comb begin
    xs = W'(op_x) <<< SHIFT;
    ys = W'(op_y) <<< SHIFT;
    if (op_x < 0) begin
      x_nxt = -xs;
      y_nxt = -ys;
      z_nxt = (op_y >= 0) ? (ZW'(1) <<< 31) : -(ZW'(1) <<< 31);
    end else begin
      x_nxt = xs;
      y_nxt = ys;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= (op_x == 0) && (op_y == 0);
    end
  end

  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign zero_out = zero_r;
endmodule

### design/rte_cordic_cell.sv
// One vectoring CORDIC iteration cell, registered.
module rte_cordic_cell #(
  parameter int W    = 39,
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [W-1:0]           x_in,
  input  logic signed [W-1:0]           y_in,
  input  logic signed [rte_pkg::ZW-1:0] z_in,
  input  logic                          zero_in,
  output logic signed [W-1:0]           x_out,
  output logic signed [W-1:0]           y_out,
  output logic signed [rte_pkg::ZW-1:0] z_out,
  output logic                          zero_out
);
  import rte_pkg::*;

  logic signed [W-1:0]  xs;
  logic signed [W-1:0]  ys;
  logic signed [ZW-1:0] ang;
  logic signed [W-1:0]  x_r;
  logic signed [W-1:0]  y_r;
  logic signed [ZW-1:0] z_r;
  logic                 zero_r;

  assign xs  = x_in >>> STEP;
  assign ys  = y_in >>> STEP;
  assign ang = signed'(ZW'(atan_at(STEP)));

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x_r <= x_in + ys;
        y_r <= y_in - xs;
        z_r <= z_in + ang;
      end else begin
        x_r <= x_in - ys;
        y_r <= y_in + xs;
        z_r <= z_in - ang;
      end
      zero_r <= zero_in;
    end
  end

  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign zero_out = zero_r;
endmodule

### design/rotation_to_euler_angles_top.sv
// Top level: rotation matrix to x-y-z Euler angles, pipelined sqrt and CORDIC.
//
// Input channel in_ch carries seven Q1.14 matrix entries per transfer; the
// result channel out_ch returns angle_x, angle_y, angle_z (binary angles,
// 32768 = pi) and the singular flag, one result per input, in order.
// cfg_ch writes the singular_limit register (reset value 1); it is always
// ready and should be written only while the pipeline is empty.
// Throughput: one matrix per cycle unless out_ch stalls. Pipeline: a register
// for the squares, one for their sum, 16 square-root digit cells, a CORDIC
// entry cell, min(CORDIC_STEPS,24) iteration cells and an output register.
// The chain advances as a whole: when out_ch holds a result that is not
// taken, every stage holds and in_ch.ready drops; bubbles hold in place too.
// Synchronous reset empties all valid bits and restores the limit.
module rotation_to_euler_angles_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 14
) (
  input  logic clk,
  input  logic rst_n,
  rte_in_if.sink    in_ch,
  rte_out_if.source out_ch,
  rte_cfg_if.sink   cfg_ch
);
  import rte_pkg::*;

  localparam int SHIFT = 30 - FRAC_BITS;
  localparam int W     = 19 + SHIFT;
  localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  logic        en;
  logic [14:0] lim_r;

  // stage 1/2 registers
  logic        v1_r;
  mat_t        m1_r;
  logic [31:0] sq00_r;
  logic [31:0] sq10_r;
  logic        v2_r;
  sqrt_t       s2_r;

  logic  sq_v [0:ROOT_W];
  sqrt_t sq_d [0:ROOT_W];

  // CORDIC lanes: 0 = x angle, 1 = y angle, 2 = z angle
  logic signed [16:0]   op_y [0:2];
  logic signed [16:0]   op_x [0:2];
  logic signed [W-1:0]  cx   [0:2][0:NSTEP];
  logic signed [W-1:0]  cy   [0:2][0:NSTEP];
  logic signed [ZW-1:0] cz   [0:2][0:NSTEP];
  logic                 czr  [0:2][0:NSTEP];
  logic                 cv_r   [0:NSTEP];
  logic                 sing_r [0:NSTEP];
  logic                 sing_nxt;
  logic signed [ZW-1:0] zr   [0:2];
  logic [15:0]          ang  [0:2];

  logic               out_valid_r;
  logic signed [15:0] ax_r;
  logic signed [15:0] ay_r;
  logic signed [15:0] az_r;
  logic               sing_out_r;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  // hold the limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 15'd1;
    end else if (cfg_ch.valid) begin
      lim_r <= cfg_ch.singular_limit;
    end
  end

  // square the first-column entries, then sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r.r00 <= in_ch.r00;
      m1_r.r10 <= in_ch.r10;
      m1_r.r20 <= in_ch.r20;
      m1_r.r21 <= in_ch.r21;
      m1_r.r22 <= in_ch.r22;
      m1_r.r11 <= in_ch.r11;
      m1_r.r12 <= in_ch.r12;
      sq00_r   <= 32'(in_ch.r00) * 32'(in_ch.r00);
      sq10_r   <= 32'(in_ch.r10) * 32'(in_ch.r10);
      s2_r.mat  <= m1_r;
      s2_r.sum  <= sq00_r + sq10_r;
      s2_r.rem  <= '0;
      s2_r.root <= '0;
    end
  end

  assign sq_v[0] = v2_r;
  assign sq_d[0] = s2_r;

  // square-root digit chain, most significant pair first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    rte_sqrt_cell #(.PAIR(ROOT_W - 1 - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (sq_v[k]),
      .in_data  (sq_d[k]),
      .out_valid(sq_v[k+1]),
      .out_data (sq_d[k+1])
    );
  end

  // pick the CORDIC operands for each angle
  always_comb begin
    sing_nxt = sq_d[ROOT_W].root < {1'b0, lim_r};
    if (sing_nxt) begin
      op_y[0] = -17'(sq_d[ROOT_W].mat.r12);
      op_x[0] = 17'(sq_d[ROOT_W].mat.r11);
    end else begin
      op_y[0] = 17'(sq_d[ROOT_W].mat.r21);
      op_x[0] = 17'(sq_d[ROOT_W].mat.r22);
    end
    op_y[1] = -17'(sq_d[ROOT_W].mat.r20);
    op_x[1] = signed'({1'b0, sq_d[ROOT_W].root});
    op_y[2] = 17'(sq_d[ROOT_W].mat.r10);
    op_x[2] = 17'(sq_d[ROOT_W].mat.r00);
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rte_cordic_entry #(.W(W), .SHIFT(SHIFT)) u_entry (
      .clk     (clk),
      .en      (en),
      .op_y    (op_y[l]),
      .op_x    (op_x[l]),
      .x_out   (cx[l][0]),
      .y_out   (cy[l][0]),
      .z_out   (cz[l][0]),
      .zero_out(czr[l][0])
    );
    for (genvar s = 0; s < NSTEP; s++) begin : g_step
      rte_cordic_cell #(.W(W), .STEP(s)) u_cell (
        .clk     (clk),
        .en      (en),
        .x_in    (cx[l][s]),
        .y_in    (cy[l][s]),
        .z_in    (cz[l][s]),
        .zero_in (czr[l][s]),
        .x_out   (cx[l][s+1]),
        .y_out   (cy[l][s+1]),
        .z_out   (cz[l][s+1]),
        .zero_out(czr[l][s+1])
      );
    end
    // round to 16-bit binary angle, origin answers zero
    assign zr[l]  = cz[l][NSTEP] + ZW'(32768);
    assign ang[l] = czr[l][NSTEP] ? 16'd0 : zr[l][31:16];
  end

  // carry valid and the singular flag alongside the CORDIC chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NSTEP; s++) begin
        cv_r[s] <= 1'b0;
      end
    end else if (en) begin
      cv_r[0] <= sq_v[ROOT_W];
      for (int s = 1; s <= NSTEP; s++) begin
        cv_r[s] <= cv_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r[0] <= sing_nxt;
      for (int s = 1; s <= NSTEP; s++) begin
        sing_r[s] <= sing_r[s-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r       <= signed'(ang[0]);
      ay_r       <= signed'(ang[1]);
      az_r       <= sing_r[NSTEP] ? 16'sd0 : signed'(ang[2]);
      sing_out_r <= sing_r[NSTEP];
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.angle_x  = ax_r;
  assign out_ch.angle_y  = ay_r;
  assign out_ch.angle_z  = az_r;
  assign out_ch.singular = sing_out_r;

  // a singular result carries no z rotation
  a_sing_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.singular |-> out_ch.angle_z == 16'sd0)
    else $error("singular result with nonzero angle_z");

  // pitch stays within a half turn
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.angle_y >= -16'sd16384) && (out_ch.angle_y <= 16'sd16384))
    else $error("angle_y outside +-pi/2");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  // a zero limit never flags a singular matrix
  a_lim0: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && lim_r == 15'd0 |-> !out_ch.singular)
    else $error("singular flagged with zero limit");
endmodule

### sim/rte_checker.sv
// Checker: predicts Euler angles for every accepted matrix and compares results.
module rte_checker (
  input  logic clk,
  input  logic rst_n,
  rte_in_if    in_ch,
  rte_out_if   out_ch,
  rte_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   singular_seen
);

  localparam int STEPS = 16;
  localparam int SHIFT = 16;  // 30 working bits less 14 fraction bits

  typedef struct {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               singular;
  } angles_t;

  // atan(2^-i), 2^31 = pi
  localparam longint ARCTAN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

  logic [14:0] limit;
  angles_t     angle_queue[$];

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 40;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] vector_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    x = x * (64'sd1 << SHIFT);
    y = y * (64'sd1 << SHIFT);
    // fold the left half-plane onto the right, starting at +/- pi
    if (x < 0) begin
      z = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN[i];
      end
    end
    return 16'((z + 32768) >>> 16);
  endfunction

  function automatic angles_t euler_predict(logic [14:0] lim,
                                            logic signed [15:0] r00, r10, r20,
                                            logic signed [15:0] r21, r22, r11, r12);
    angles_t a;
    longint unsigned sy;
    sy = int_sqrt(longint'(r00) * r00 + longint'(r10) * r10);
    a.singular = (sy < lim);
    a.angle_y = vector_angle(-longint'(r20), longint'(sy));
    if (!a.singular) begin
      a.angle_x = vector_angle(r21, r22);
      a.angle_z = vector_angle(r10, r00);
    end else begin
      a.angle_x = vector_angle(-longint'(r12), r11);
      a.angle_z = 16'sd0;
    end
    return a;
  endfunction

  // track the limit, queue predictions, compare each result transfer
  always @(posedge clk) begin
    angles_t exp_a;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      limit <= 15'd1;
      angle_queue.delete();
      fail_count <= 0;
      singular_seen <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) limit <= cfg_ch.singular_limit;
      if (in_ch.valid && in_ch.ready)
        angle_queue = {angle_queue, euler_predict(limit, in_ch.r00, in_ch.r10, in_ch.r20,
                                                  in_ch.r21, in_ch.r22, in_ch.r11,
                                                  in_ch.r12)};
      if (out_ch.valid && out_ch.ready) begin
        if (angle_queue.size() == 0) begin
          $error("result transfer with no matrix outstanding");
          errs++;
        end else begin
          exp_a = angle_queue.pop_front();
          if (exp_a.singular) singular_seen <= singular_seen + 1;
          if (out_ch.angle_x !== exp_a.angle_x) begin
            $error("angle_x expected %0d actual %0d", exp_a.angle_x, out_ch.angle_x);
            errs++;
          end
          if (out_ch.angle_y !== exp_a.angle_y) begin
            $error("angle_y expected %0d actual %0d", exp_a.angle_y, out_ch.angle_y);
            errs++;
          end
          if (out_ch.angle_z !== exp_a.angle_z) begin
            $error("angle_z expected %0d actual %0d", exp_a.angle_z, out_ch.angle_z);
            errs++;
          end
          if (out_ch.singular !== exp_a.singular) begin
            $error("singular expected %0b actual %0b", exp_a.singular, out_ch.singular);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= angle_queue.size();
  end

endmodule

### sim/testbench.sv
// Top of the testbench: clock, reset, matrix stimulus, limit writes and verdict.
module testbench;
  import rte_pkg::*;

  localparam int LATENCY = 36;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, singular_seen;
  int   cycles = 0;
  int   sent = 0;
  bit   calm = 1'b0;
  int   stall_left = 0;

  rte_in_if  in_if();
  rte_out_if out_if();
  rte_cfg_if cfg_if();

  rotation_to_euler_angles_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if));

  rte_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if),
    .fail_count(fail_count), .pending(pending), .singular_seen(singular_seen));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall before each transfer unless calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      stall_left = calm ? 0 : $urandom_range(0, 5);
      out_if.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_if.ready <= (stall_left == 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_matrix(mat_t m);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.r00 <= m.r00; in_if.r10 <= m.r10; in_if.r20 <= m.r20;
    in_if.r21 <= m.r21; in_if.r22 <= m.r22; in_if.r11 <= m.r11;
    in_if.r12 <= m.r12;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  // hold off until the pipeline is empty, then let it settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_limit(logic [14:0] lim);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.singular_limit <= lim;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] entry();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic mat_t random_matrix();
    mat_t         m;
    int           kind;
    logic [127:0] raw;
    kind = $urandom_range(0, 9);
    m.r00 = entry(); m.r10 = entry(); m.r20 = entry(); m.r21 = entry();
    m.r22 = entry(); m.r11 = entry(); m.r12 = entry();
    if (kind < 3) begin
      // near gimbal lock: small first column, |r20| near one
      m.r00 = 16'($signed($urandom_range(0, 256)) - 128);
      m.r10 = 16'($signed($urandom_range(0, 256)) - 128);
      m.r20 = $urandom_range(0, 1) ? 16'sd16384 - 16'($urandom_range(0, 8))
                                   : -16'sd16384 + 16'($urandom_range(0, 8));
    end else if (kind == 3) begin
      // any bit pattern
      raw = {$urandom, $urandom, $urandom, $urandom};
      m = raw[111:0];
    end else if (kind == 4) begin
      m.r10 = 16'sd0;
      m.r21 = 16'sd0;
    end
    return m;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_matrix(random_matrix());
  endtask

  task automatic directed_phase();
    mat_t d [12];
    d[0] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    d[1] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0};
    d[2] = '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
             16'sd16384, 16'sd16384};
    d[3] = '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
             -16'sd16384, -16'sd16384};
    d[4] = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
             16'sh8000, 16'sh8000};
    d[5] = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
             16'sd32767, 16'sd32767};
    // gimbal lock both ways
    d[6] = '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd5000};
    d[7] = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd9000, -16'sd7000};
    // left half-plane with y zero (wraps pi) and y negative
    d[8] = '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, -16'sd16384, 16'sd0};
    d[9] = '{-16'sd8000, -16'sd9000, 16'sd100, -16'sd50, -16'sd12000, -16'sd1,
             16'sd1};
    d[10] = '{16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd0, -16'sd1};
    d[11] = '{16'sd1, 16'sd0, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd0};
    foreach (d[i]) send_matrix(d[i]);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.r00 = '0; in_if.r10 = '0; in_if.r20 = '0; in_if.r21 = '0;
    in_if.r22 = '0; in_if.r11 = '0; in_if.r12 = '0;
    cfg_if.valid = 1'b0;
    cfg_if.singular_limit = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit of one
    directed_phase();
    random_phase(160);
    write_limit(15'd0);
    directed_phase();
    random_phase(150);
    write_limit(15'd16384);
    random_phase(200);
    calm = 1'b1;
    random_phase(100);
    calm = 1'b0;
    write_limit(15'd200);
    random_phase(200);
    write_limit(15'($urandom_range(1, 16383)));
    random_phase(200);
    drain();
    write_limit(15'd1);
    directed_phase();

    drain();
    $display("Sent %0d matrices over five limit values (0, 1, 200, 16384, random);",
             sent);
    $display("%0d results took the singular path.", singular_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### rotation_to_euler_angles_top.f
design/rte_pkg.sv
design/rte_ifs.sv
design/rte_sqrt_cell.sv
design/rte_cordic_entry.sv
design/rte_cordic_cell.sv
design/rotation_to_euler_angles_top.sv
sim/rte_checker.sv
sim/testbench.sv
